// ----- src/sba_pkg.sv -----
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types, codes and constants of the slab block allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

	// Sizing defaults
	localparam int unsigned MAX_BLOCKS = 1024;
	localparam int unsigned LINK_BYTES = 8;
	localparam int unsigned PAGE_BYTES = 32'h1000;
	localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

	// Field widths
	localparam int unsigned OP_W       = 2;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned PAGES_W    = 8;
	localparam int unsigned BSIZE_W    = 16;
	localparam int unsigned STRIDE_W   = BSIZE_W + 1;
	localparam int unsigned NUM_W      = PAGES_W + PAGE_SHIFT;
	localparam int unsigned STEP_W     = $clog2(NUM_W);
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_INVALID  = 3'd2,
		ST_NULL     = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// Command kinds after front-end classification
	typedef enum logic [2:0] {
		CMD_INIT,
		CMD_ALLOC,
		CMD_FREE,
		CMD_NULL,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic [PAGES_W-1:0] page_count;
		logic [BSIZE_W-1:0] block_bytes;
		logic [ADDR_W-1:0]  region_base;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ALLOC,
		BK_DIV,
		BK_SIZE,
		BK_FILL,
		BK_END
	} bk_state_t;

endpackage

// ----- src/sba_ram.sv -----
// ----------------------------------------------------------------------------
// sba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/sba_front.sv -----
// ----------------------------------------------------------------------------
// sba_front
// Accepts input items, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module sba_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [sba_pkg::OP_W-1:0]   opcode,
	input  logic [sba_pkg::ADDR_W-1:0] free_address,
	output logic                       cmd_valid,
	input  logic                       cmd_pop,
	output sba_pkg::cmd_t              cmd
);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned PTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
	localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

	sba_pkg::cmd_t     slot_q [QDEPTH];
	sba_pkg::cmd_t     new_cmd;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;

	// Classify the incoming item
	always_comb begin
		new_cmd.addr = free_address;
		case (opcode)
			sba_pkg::OP_INIT:  new_cmd.kind = sba_pkg::CMD_INIT;
			sba_pkg::OP_ALLOC: new_cmd.kind = sba_pkg::CMD_ALLOC;
			sba_pkg::OP_FREE: begin
				new_cmd.kind = (free_address == '0) ? sba_pkg::CMD_NULL : sba_pkg::CMD_FREE;
			end
			default:           new_cmd.kind = sba_pkg::CMD_NOP;
		endcase
	end

	assign in_stall  = (cnt_q == QFULL);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_ptr_q];

	// Command queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/sba_back.sv -----
// ----------------------------------------------------------------------------
// sba_back
// Executes commands against the free-list RAM and counters; drives results.
// ----------------------------------------------------------------------------
module sba_back #(
	parameter int unsigned MAX_BLOCKS = sba_pkg::MAX_BLOCKS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_pop,
	input  sba_pkg::cmd_t                      cmd,
	input  sba_pkg::cfg_t                      cfg,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sba_pkg::STATUS_W-1:0]       status,
	output logic [sba_pkg::ADDR_W-1:0]         block_address,
	output logic [$clog2(MAX_BLOCKS + 1)-1:0]  used_count,
	output logic [$clog2(MAX_BLOCKS + 1)-1:0]  total_blocks
);

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BLOCKS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);
	localparam logic [sba_pkg::STEP_W-1:0] LAST_STEP = sba_pkg::STEP_W'(sba_pkg::NUM_W - 1);

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	sba_pkg::bk_state_t state_q, state_d;
	logic [IDX_W-1:0]              head_q, head_d;
	logic [IDX_W-1:0]              tail_q, tail_d;
	logic [CNT_W-1:0]              free_q, free_d;
	logic [CNT_W-1:0]              used_q, used_d;
	logic [CNT_W-1:0]              total_q, total_d;
	logic [CNT_W-1:0]              cnt_q, cnt_d;
	logic [IDX_W-1:0]              fill_q, fill_d;
	logic [sba_pkg::ADDR_W-1:0]    fill_addr_q, fill_addr_d;
	logic                          init_bad_q, init_bad_d;
	logic [sba_pkg::STRIDE_W-1:0]  stride_q, stride_d;
	logic [sba_pkg::STRIDE_W-1:0]  rem_q, rem_d;
	logic [sba_pkg::NUM_W-1:0]     num_q, num_d;
	logic [sba_pkg::STEP_W-1:0]    step_q, step_d;

	logic [sba_pkg::STRIDE_W:0]    trial;
	logic [sba_pkg::STRIDE_W:0]    diff;
	logic                          fits;
	logic [CNT_W-1:0]              quo_sat;

	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [sba_pkg::ADDR_W-1:0]    ram_wdata;
	logic                          ram_re;
	logic [sba_pkg::ADDR_W-1:0]    ram_rdata;

	logic                          out_free;
	logic                          emit;
	sba_pkg::status_t              emit_status;
	logic [sba_pkg::ADDR_W-1:0]    emit_addr;

	logic                          ovalid_q;
	sba_pkg::status_t              ostatus_q;
	logic [sba_pkg::ADDR_W-1:0]    oaddr_q;
	logic [CNT_W-1:0]              oused_q;
	logic [CNT_W-1:0]              ototal_q;

	sba_ram #(
		.WIDTH (sba_pkg::ADDR_W),
		.DEPTH (MAX_BLOCKS)
	) u_block_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	assign out_free = !ovalid_q || !out_stall;

	// Restoring divider step and saturated block count
	always_comb begin
		trial   = {rem_q, num_q[sba_pkg::NUM_W-1]};
		diff    = trial - {1'b0, stride_q};
		fits    = (trial >= {1'b0, stride_q});
		quo_sat = (32'(num_q) > 32'(MAX_BLOCKS)) ? MAX_CNT : CNT_W'(num_q);
	end

	// Sequencer: next state, RAM control and result selection
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		free_d      = free_q;
		used_d      = used_q;
		total_d     = total_q;
		cnt_d       = cnt_q;
		fill_d      = fill_q;
		fill_addr_d = fill_addr_q;
		init_bad_d  = init_bad_q;
		stride_d    = stride_q;
		rem_d       = rem_q;
		num_d       = num_q;
		step_d      = step_q;
		cmd_pop     = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = tail_q;
		ram_wdata   = cmd.addr;
		ram_re      = 1'b0;
		emit        = 1'b0;
		emit_status = sba_pkg::ST_OK;
		emit_addr   = '0;

		case (state_q)
			sba_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						sba_pkg::CMD_INIT: begin
							cmd_pop  = 1'b1;
							head_d   = '0;
							tail_d   = '0;
							free_d   = '0;
							used_d   = '0;
							total_d  = '0;
							stride_d = sba_pkg::STRIDE_W'(cfg.block_bytes)
								+ sba_pkg::STRIDE_W'(sba_pkg::LINK_BYTES);
							num_d    = {cfg.page_count, {sba_pkg::PAGE_SHIFT{1'b0}}};
							rem_d    = '0;
							step_d   = '0;
							state_d  = sba_pkg::BK_DIV;
						end
						sba_pkg::CMD_ALLOC: begin
							if (free_q == '0) begin
								if (out_free) begin
									cmd_pop     = 1'b1;
									emit        = 1'b1;
									emit_status = sba_pkg::ST_EMPTY;
								end
							end else begin
								// pop oldest entry; data returns next cycle
								cmd_pop = 1'b1;
								ram_re  = 1'b1;
								head_d  = next_idx(head_q);
								free_d  = free_q - 1'b1;
								if (used_q < MAX_CNT) begin
									used_d = used_q + 1'b1;
								end
								state_d = sba_pkg::BK_ALLOC;
							end
						end
						sba_pkg::CMD_FREE: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								emit    = 1'b1;
								if (free_q >= MAX_CNT) begin
									emit_status = sba_pkg::ST_OVERFLOW;
								end else begin
									ram_we = 1'b1;
									tail_d = next_idx(tail_q);
									free_d = free_q + 1'b1;
									if (used_q != '0) begin
										used_d = used_q - 1'b1;
									end
								end
							end
						end
						sba_pkg::CMD_NULL: begin
							if (out_free) begin
								cmd_pop     = 1'b1;
								emit        = 1'b1;
								emit_status = sba_pkg::ST_NULL;
							end
						end
						default: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								emit    = 1'b1;
							end
						end
					endcase
				end
			end
			sba_pkg::BK_ALLOC: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_addr = ram_rdata;
					state_d   = sba_pkg::BK_IDLE;
				end
			end
			sba_pkg::BK_DIV: begin
				// one quotient bit per cycle
				rem_d  = fits ? diff[sba_pkg::STRIDE_W-1:0] : trial[sba_pkg::STRIDE_W-1:0];
				num_d  = {num_q[sba_pkg::NUM_W-2:0], fits};
				step_d = step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = sba_pkg::BK_SIZE;
				end
			end
			sba_pkg::BK_SIZE: begin
				cnt_d       = quo_sat;
				fill_d      = '0;
				fill_addr_d = cfg.region_base;
				init_bad_d  = (cfg.block_bytes == '0) || (quo_sat == '0);
				state_d     = init_bad_d ? sba_pkg::BK_END : sba_pkg::BK_FILL;
			end
			sba_pkg::BK_FILL: begin
				// one block address written per cycle
				ram_we      = 1'b1;
				ram_waddr   = fill_q;
				ram_wdata   = fill_addr_q;
				fill_d      = fill_q + 1'b1;
				fill_addr_d = fill_addr_q + sba_pkg::ADDR_W'(stride_q);
				if (CNT_W'(fill_q) == cnt_q - 1'b1) begin
					state_d = sba_pkg::BK_END;
				end
			end
			sba_pkg::BK_END: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = sba_pkg::BK_IDLE;
					if (init_bad_q) begin
						emit_status = sba_pkg::ST_INVALID;
					end else begin
						free_d  = cnt_q;
						total_d = cnt_q;
						tail_d  = (cnt_q == MAX_CNT) ? '0 : IDX_W'(cnt_q);
					end
				end
			end
			default: begin
				state_d = sba_pkg::BK_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sba_pkg::BK_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			free_q     <= '0;
			used_q     <= '0;
			total_q    <= '0;
			cnt_q      <= '0;
			fill_q     <= '0;
			init_bad_q <= 1'b0;
			step_q     <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			free_q     <= free_d;
			used_q     <= used_d;
			total_q    <= total_d;
			cnt_q      <= cnt_d;
			fill_q     <= fill_d;
			init_bad_q <= init_bad_d;
			step_q     <= step_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Datapath and result registers
	always_ff @(posedge clk) begin
		fill_addr_q <= fill_addr_d;
		stride_q    <= stride_d;
		rem_q       <= rem_d;
		num_q       <= num_d;
		if (emit) begin
			ostatus_q <= emit_status;
			oaddr_q   <= emit_addr;
			oused_q   <= used_d;
			ototal_q  <= total_d;
		end
	end

	assign out_valid     = ovalid_q;
	assign status        = ostatus_q;
	assign block_address = oaddr_q;
	assign used_count    = oused_q;
	assign total_blocks  = ototal_q;

endmodule

// ----- src/slab_block_allocator.sv -----
// ----------------------------------------------------------------------------
// slab_block_allocator
// Fixed-block allocator over a memory region with a FIFO free list.
// ----------------------------------------------------------------------------
// Allocate: the back end takes no new command until the registered read port of
//   the free-list RAM returns the address; free, no-op and rejected items do not.
// Init: dispatch, a bit-serial divide, a sizing step, the free-list writes of
//   every block (skipped for invalid settings) and the report.
// Results pass the command queue, then the result register; allocate also reads RAM.
// Reset: arst_n clears queue pointers and counts; RAM contents stay undefined.
// ----------------------------------------------------------------------------
module slab_block_allocator #(
	parameter int unsigned MAX_BLOCKS = sba_pkg::MAX_BLOCKS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sba_pkg::OP_W-1:0]           opcode,
	input  logic [sba_pkg::ADDR_W-1:0]         free_address,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sba_pkg::STATUS_W-1:0]       status,
	output logic [sba_pkg::ADDR_W-1:0]         block_address,
	output logic [$clog2(MAX_BLOCKS + 1)-1:0]  used_count,
	output logic [$clog2(MAX_BLOCKS + 1)-1:0]  total_blocks,
	input  logic                               cfg_write,
	input  logic [sba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	sba_pkg::cfg_t cfg_q;
	sba_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.page_count  <= sba_pkg::PAGES_W'(1);
			cfg_q.block_bytes <= sba_pkg::BSIZE_W'(32);
			cfg_q.region_base <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				sba_pkg::CFG_PAGE_COUNT:  cfg_q.page_count  <= cfg_data[sba_pkg::PAGES_W-1:0];
				sba_pkg::CFG_BLOCK_BYTES: cfg_q.block_bytes <= cfg_data[sba_pkg::BSIZE_W-1:0];
				sba_pkg::CFG_REGION_BASE: cfg_q.region_base <= cfg_data[sba_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	sba_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.free_address (free_address),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd)
	);

	sba_back #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.block_address (block_address),
		.used_count    (used_count),
		.total_blocks  (total_blocks)
	);

endmodule

// ----- src/sba_checker.sv -----
// ----------------------------------------------------------------------------
// sba_checker
// Port-level checks of the slab block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sba_checker #(
	parameter int unsigned MAX_BLOCKS = sba_pkg::MAX_BLOCKS
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [sba_pkg::STATUS_W-1:0]       status,
	input logic [sba_pkg::ADDR_W-1:0]         block_address,
	input logic [$clog2(MAX_BLOCKS + 1)-1:0]  used_count,
	input logic [$clog2(MAX_BLOCKS + 1)-1:0]  total_blocks
);

	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(block_address)
			&& $stable(used_count) && $stable(total_blocks))
		else $error("result changed while stalled");

	// Only a successful allocate carries an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != sba_pkg::ST_OK) |-> block_address == '0)
		else $error("address on a non-ok result");

	// Counts never pass the block limit
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (used_count <= CNT_W'(MAX_BLOCKS)) && (total_blocks <= CNT_W'(MAX_BLOCKS)))
		else $error("count above limit");

	// A rejected init leaves an empty allocator
	a_bad_init: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sba_pkg::ST_INVALID) |-> used_count == '0 && total_blocks == '0)
		else $error("counts survive an invalid init");

	// Status codes stay in the defined set
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == sba_pkg::ST_OK || status == sba_pkg::ST_EMPTY
			|| status == sba_pkg::ST_INVALID || status == sba_pkg::ST_NULL
			|| status == sba_pkg::ST_OVERFLOW)
		else $error("undefined status code");

endmodule

bind slab_block_allocator sba_checker #(
	.MAX_BLOCKS (MAX_BLOCKS)
) u_sba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.block_address (block_address),
	.used_count    (used_count),
	.total_blocks  (total_blocks)
);

// ----- bench/slab_block_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// slab_block_allocator_tb
// Checks the slab block allocator against a transaction-level predictor of the
// free list, the used count and the block total. A short directed part covers
// reset state, invalid settings, address wrap, null frees and a full queue;
// random traffic then mixes allocs, frees of handed-out blocks, foreign and
// null frees, re-inits and no-ops under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module slab_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sba_pkg::*;

	localparam int unsigned CNT_W         = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned STUCK_LIMIT   = 5000;
	localparam int unsigned SETTLE_CYCLES = 8;
	// index with no register behind it; writes must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		status_t            status;
		logic [ADDR_W-1:0]  addr;
		logic [CNT_W-1:0]   used;
		logic [CNT_W-1:0]   total;
	} alloc_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [OP_W-1:0]       opcode = OP_NOP;
	logic [ADDR_W-1:0]     free_address = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [ADDR_W-1:0]     block_address;
	logic [CNT_W-1:0]      used_count;
	logic [CNT_W-1:0]      total_blocks;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [PAGES_W-1:0]    cfg_pages = 8'd1;
	logic [BSIZE_W-1:0]    cfg_bytes = 16'd32;
	logic [ADDR_W-1:0]     cfg_base = '0;
	logic [ADDR_W-1:0]     free_pool[$];
	int unsigned           used_cnt = 0;
	int unsigned           total_cnt = 0;
	logic [ADDR_W-1:0]     handed_out[$];
	alloc_result_t         pending_results[$];

	int unsigned errors = 0;
	int unsigned stuck_cycles = 0;
	int unsigned stall_left = 0;
	bit          no_idle = 1'b0;

	slab_block_allocator uut (.*);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// expected result of one accepted item; updates the free list model
	function automatic void predict_result(opcode_t op, logic [ADDR_W-1:0] addr);
		alloc_result_t     r;
		longint unsigned   stride;
		longint unsigned   count;
		logic [ADDR_W-1:0] next_addr;
		r.status = ST_OK;
		r.addr = '0;
		case (op)
			OP_INIT: begin
				// any init discards the queue and outstanding blocks
				free_pool.delete();
				handed_out.delete();
				used_cnt = 0;
				total_cnt = 0;
				stride = 64'(cfg_bytes) + LINK_BYTES;
				count = (64'(cfg_pages) * PAGE_BYTES) / stride;
				if (count > MAX_BLOCKS)
					count = 64'(MAX_BLOCKS);
				if (cfg_bytes == 0 || count == 0) begin
					r.status = ST_INVALID;
				end else begin
					next_addr = cfg_base;
					for (int i = 0; i < int'(count); i++) begin
						free_pool.push_back(next_addr);
						next_addr = next_addr + stride[ADDR_W-1:0];
					end
					total_cnt = 32'(count);
				end
			end
			OP_ALLOC: begin
				if (free_pool.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.addr = free_pool.pop_front();
					if (used_cnt < MAX_BLOCKS)
						used_cnt++;
					handed_out.push_back(r.addr);
				end
			end
			OP_FREE: begin
				if (addr == '0) begin
					r.status = ST_NULL;
				end else if (free_pool.size() >= MAX_BLOCKS) begin
					r.status = ST_OVERFLOW;
				end else begin
					free_pool.push_back(addr);
					if (used_cnt > 0)
						used_cnt--;
				end
			end
			default: ;
		endcase
		r.used = CNT_W'(used_cnt);
		r.total = CNT_W'(total_cnt);
		pending_results.push_back(r);
	endfunction

	// one input transfer, optionally preceded by a gap
	task automatic send_item(opcode_t op, logic [ADDR_W-1:0] addr);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		free_address <= addr;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_result(op, addr);
	endtask

	// hold off the sender until every result is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_PAGE_COUNT:  cfg_pages = data[PAGES_W-1:0];
			CFG_BLOCK_BYTES: cfg_bytes = data[BSIZE_W-1:0];
			CFG_REGION_BASE: cfg_base = data;
			default: ;
		endcase
	endtask

	// reprogram all registers while idle; unused upper data bits carry noise
	task automatic set_region(logic [PAGES_W-1:0] pages, logic [BSIZE_W-1:0] bytes,
			logic [ADDR_W-1:0] base);
		logic [CFG_DATA_W-1:0] junk;
		drain();
		junk = $urandom;
		write_reg(CFG_PAGE_COUNT, {junk[CFG_DATA_W-1:PAGES_W], pages});
		junk = $urandom;
		write_reg(CFG_BLOCK_BYTES, {junk[CFG_DATA_W-1:BSIZE_W], bytes});
		write_reg(CFG_REGION_BASE, base);
		write_reg(CFG_SPARE, $urandom);
		cfg_write <= 1'b0;
	endtask

	// init, then a mix of allocs, frees (mostly of blocks handed out earlier), rare re-inits and no-ops
	task automatic random_traffic(int unsigned n);
		int unsigned       r;
		int unsigned       k;
		int unsigned       pick;
		logic [ADDR_W-1:0] a;
		send_item(OP_INIT, $urandom);
		for (int unsigned i = 1; i < n; i++) begin
			if (i == n / 2)
				drain();
			r = $urandom_range(0, 99);
			a = $urandom;
			if (r < 2) begin
				send_item(OP_INIT, a);
			end else if (r < 6) begin
				send_item(OP_NOP, a);
			end else if (r < 52) begin
				send_item(OP_ALLOC, a);
			end else begin
				k = $urandom_range(0, 99);
				if (k < 70 && handed_out.size() > 0) begin
					pick = $urandom_range(0, handed_out.size() - 1);
					a = handed_out[pick];
					handed_out.delete(pick);
				end else if (k < 80) begin
					a = '0;
				end
				send_item(OP_FREE, a);
			end
		end
	endtask

	// state right after reset, null and foreign frees, first init
	task automatic test_after_reset();
		send_item(OP_ALLOC, 32'h0000_1000);
		send_item(OP_FREE, '0);
		send_item(OP_NOP, 32'hFFFF_FFFF);
		send_item(OP_FREE, 32'hFFFF_FFFF);
		send_item(OP_ALLOC, '0);
		send_item(OP_INIT, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
	endtask

	// zero block size, zero pages, block larger than the region, largest block
	task automatic test_invalid_settings();
		set_region(8'd1, 16'd0, 32'h0000_1000);
		send_item(OP_INIT, '0);
		send_item(OP_ALLOC, '0);
		set_region(8'd0, 16'd32, '0);
		send_item(OP_INIT, '0);
		set_region(8'd1, 16'd4096, '0);
		send_item(OP_INIT, '0);
		set_region(8'd255, 16'hFFFF, 32'h8000_0000);
		send_item(OP_INIT, '0);
		send_item(OP_ALLOC, '0);
	endtask

	// block addresses roll over 2^32; a null free is refused even for a real block
	task automatic test_address_wrap();
		set_region(8'd1, 16'd8, 32'hFFFF_FFF0);
		send_item(OP_INIT, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, '0);
	endtask

	// saturated block count, overflow on a full queue, re-init with blocks out
	task automatic test_full_queue();
		set_region(8'd255, 16'd1, 32'hFFFF_FFFF);
		send_item(OP_INIT, '0);
		send_item(OP_FREE, 32'h0000_1234);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, 32'hDEAD_BEEF);
		send_item(OP_FREE, 32'h0000_0055);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_INIT, '0);
	endtask

	task automatic test_random_small_regions();
		repeat (2) begin
			set_region(PAGES_W'($urandom_range(1, 3)), BSIZE_W'($urandom_range(1, 200)),
				$urandom);
			random_traffic(200);
		end
	endtask

	task automatic test_random_full_range();
		set_region(PAGES_W'($urandom), BSIZE_W'($urandom), $urandom);
		random_traffic(200);
	endtask

	task automatic test_random_no_idle();
		no_idle = 1'b1;
		set_region(PAGES_W'($urandom_range(1, 2)), BSIZE_W'($urandom_range(8, 120)),
			$urandom);
		random_traffic(200);
		no_idle = 1'b0;
	endtask

	task automatic test_random_largest_region();
		set_region(8'd255, 16'd1, $urandom);
		random_traffic(200);
	endtask

	// result checking and receiver back-pressure
	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no item outstanding, status %0d", status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (block_address !== want.addr) begin
					$error("block_address: expected %h, got %h", want.addr, block_address);
					errors++;
				end
				if (used_count !== want.used) begin
					$error("used_count: expected %0d, got %0d", want.used, used_count);
					errors++;
				end
				if (total_blocks !== want.total) begin
					$error("total_blocks: expected %0d, got %0d", want.total, total_blocks);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_left = pick_gap();
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && in_stall === 1'b0)
				|| (out_valid === 1'b1 && out_stall === 1'b0)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("slab_block_allocator: mismatch");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_invalid_settings();
		test_address_wrap();
		test_full_queue();
		test_random_small_regions();
		test_random_full_range();
		test_random_no_idle();
		test_random_largest_region();
		drain();
		if (errors == 0)
			$display("slab_block_allocator: match");
		else
			$display("slab_block_allocator: mismatch");
		$finish;
	end

endmodule
